>>> rtl/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared types and constants of the union-find unit: request codes, field
// widths, the rank ceiling and the operation codes of the shared datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dsu_pkg;

   // Fixed field widths
   localparam int INDEX_W = 10;
   localparam int ROWS_W  = 32;
   localparam int RANK_W  = 4;

   // Rank saturates here
   localparam logic [RANK_W-1:0] RANK_MAX = '1;

   // Request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_MERGE = 1'b1;

   // Shared datapath operations
   typedef enum logic {
      ALU_ADD_SAT,
      ALU_MAX
   } alu_op_type;

endpackage

`default_nettype wire

>>> rtl/disjoint_set_union_max_size_unit.sv
// ----------------------------------------------------------------------------
// disjoint_set_union_max_size_unit
// Union-find over NUM_TABLES entries with union by rank, full path
// compression and a running maximum of set row counts.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its tables (busy high) so that every entry
// is its own root with rank 0 and no rows. A request is taken when start
// is high and busy is low; busy then stays high until the response. Exactly
// one response per request: rsp_valid is high for one cycle with
// rsp_largest_size, and the receiver cannot stall it. A load answers from
// LOAD, a request with an index at or above NUM_TABLES from DONE. A merge
// walks each entry to its root (FIND_WALK) and compresses its path
// (FIND_FIX), then joins the roots in JOIN_RD, JOIN_CMP and JOIN_WR; a
// merge of two entries already in one set skips the join and answers
// from FIND_FIX. Every step of the root walk and of the compression pass
// is one read of the parent memory, whose single read port sets the pace.
// Depths stay at most log2(NUM_TABLES). The next request may be given in
// the cycle of the response.
// ----------------------------------------------------------------------------
`default_nettype none

module disjoint_set_union_max_size_unit #(
   parameter int NUM_TABLES = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_type,
   input  wire logic [dsu_pkg::INDEX_W-1:0]  req_index_a,
   input  wire logic [dsu_pkg::INDEX_W-1:0]  req_index_b,
   input  wire logic [dsu_pkg::ROWS_W-1:0]   req_row_count,
   output logic                              rsp_valid,
   output logic      [dsu_pkg::ROWS_W-1:0]   rsp_largest_size
);

   import dsu_pkg::*;

   localparam int IW = $clog2(NUM_TABLES);
   localparam logic [IW-1:0] LAST_INDEX = IW'(NUM_TABLES - 1);

   typedef enum logic [3:0] {
      CLEAR,
      IDLE,
      LOAD,
      FIND_WALK,
      FIND_FIX,
      JOIN_RD,
      JOIN_CMP,
      JOIN_WR,
      DONE
   } state_type;

   // Control registers
   state_type         state_ff, state_in;
   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROWS_W-1:0] largest_ff, largest_in;
   logic [IW-1:0]     clr_ff, clr_in;

   // Working registers
   logic              side_ff, side_in;
   logic [IW-1:0]     node_ff, node_in;
   logic [IW-1:0]     cur_ff, cur_in;
   logic [IW-1:0]     walk_ff, walk_in;
   logic [IW-1:0]     root_a_ff, root_a_in;
   logic [IW-1:0]     b_ff, b_in;
   logic [IW-1:0]     top_ff, top_in;
   logic [ROWS_W-1:0] rows_ff, rows_in;
   logic [ROWS_W-1:0] rows_a_ff, rows_a_in;
   logic [ROWS_W-1:0] sum_ff, sum_in;
   logic [RANK_W-1:0] rank_a_ff, rank_a_in;

   // Memory ports
   logic              par_we;
   logic [IW-1:0]     par_waddr, par_wdata, par_raddr, par_rd;
   logic              rk_we;
   logic [IW-1:0]     rk_waddr;
   logic [RANK_W-1:0] rk_wdata, rk_rd;
   logic              rw_we;
   logic [IW-1:0]     rw_waddr;
   logic [ROWS_W-1:0] rw_wdata, rw_rd;
   logic [IW-1:0]     tab_raddr;

   // Shared unit
   alu_op_type        alu_op;
   logic [ROWS_W-1:0] alu_a, alu_b, alu_res;

   logic a_ok, b_ok;

   assign a_ok = int'(req_index_a) < NUM_TABLES;
   assign b_ok = int'(req_index_b) < NUM_TABLES;

   dsu_ram #(.WIDTH(IW), .DEPTH(NUM_TABLES)) u_parent (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_waddr),
      .wr_data (par_wdata),
      .rd_addr (par_raddr),
      .rd_data (par_rd)
   );

   dsu_ram #(.WIDTH(RANK_W), .DEPTH(NUM_TABLES)) u_rank (
      .clock   (clock),
      .wr_en   (rk_we),
      .wr_addr (rk_waddr),
      .wr_data (rk_wdata),
      .rd_addr (tab_raddr),
      .rd_data (rk_rd)
   );

   dsu_ram #(.WIDTH(ROWS_W), .DEPTH(NUM_TABLES)) u_rows (
      .clock   (clock),
      .wr_en   (rw_we),
      .wr_addr (rw_waddr),
      .wr_data (rw_wdata),
      .rd_addr (tab_raddr),
      .rd_data (rw_rd)
   );

   dsu_alu u_alu (
      .op     (alu_op),
      .opnd_a (alu_a),
      .opnd_b (alu_b),
      .result (alu_res)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      largest_in   = largest_ff;
      clr_in       = clr_ff;
      side_in      = side_ff;
      node_in      = node_ff;
      cur_in       = cur_ff;
      walk_in      = walk_ff;
      root_a_in    = root_a_ff;
      b_in         = b_ff;
      top_in       = top_ff;
      rows_in      = rows_ff;
      rows_a_in    = rows_a_ff;
      sum_in       = sum_ff;
      rank_a_in    = rank_a_ff;

      par_we    = 1'b0;
      par_waddr = walk_ff;
      par_wdata = cur_ff;
      par_raddr = cur_ff;
      rk_we     = 1'b0;
      rk_waddr  = cur_ff;
      rk_wdata  = '0;
      rw_we     = 1'b0;
      rw_waddr  = top_ff;
      rw_wdata  = sum_ff;
      tab_raddr = root_a_ff;

      alu_op = ALU_MAX;
      alu_a  = largest_ff;
      alu_b  = rows_ff;

      unique case (state_ff)
         // Sweep every entry back to a lone root
         CLEAR: begin
            par_we    = 1'b1;
            par_waddr = clr_ff;
            par_wdata = clr_ff;
            rk_we     = 1'b1;
            rk_waddr  = clr_ff;
            rk_wdata  = '0;
            rw_we     = 1'b1;
            rw_waddr  = clr_ff;
            rw_wdata  = '0;
            if (clr_ff == LAST_INDEX) begin
               state_in = IDLE;
               busy_in  = 1'b0;
            end else begin
               clr_in = clr_ff + IW'(1);
            end
         end

         // Take a request; start the first parent read right away
         IDLE: begin
            par_raddr = IW'(req_index_a);
            if (start) begin
               busy_in = 1'b1;
               rows_in = req_row_count;
               node_in = IW'(req_index_a);
               cur_in  = IW'(req_index_a);
               b_in    = IW'(req_index_b);
               side_in = 1'b0;
               if (req_type == REQ_MERGE && a_ok && b_ok) begin
                  state_in = FIND_WALK;
               end else if (req_type == REQ_LOAD && a_ok) begin
                  state_in = LOAD;
               end else begin
                  state_in = DONE;
               end
            end
         end

         // Store row count, track the maximum
         LOAD: begin
            rw_we        = 1'b1;
            rw_waddr     = node_ff;
            rw_wdata     = rows_ff;
            largest_in   = alu_res;
            state_in     = IDLE;
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end

         // Follow parent links up to the root
         FIND_WALK: begin
            if (par_rd == cur_ff) begin
               walk_in   = node_ff;
               par_raddr = node_ff;
               state_in  = FIND_FIX;
            end else begin
               cur_in    = par_rd;
               par_raddr = par_rd;
            end
         end

         // Second pass: point every entry on the path at the root
         FIND_FIX: begin
            if (walk_ff == cur_ff) begin
               if (!side_ff) begin
                  root_a_in = cur_ff;
                  side_in   = 1'b1;
                  node_in   = b_ff;
                  cur_in    = b_ff;
                  par_raddr = b_ff;
                  state_in  = FIND_WALK;
               end else if (root_a_ff == cur_ff) begin
                  // same set: paths compressed, nothing to join
                  state_in     = IDLE;
                  busy_in      = 1'b0;
                  rsp_valid_in = 1'b1;
               end else begin
                  tab_raddr = root_a_ff;
                  state_in  = JOIN_RD;
               end
            end else begin
               par_we    = 1'b1;
               par_waddr = walk_ff;
               par_wdata = cur_ff;
               walk_in   = par_rd;
               par_raddr = par_rd;
            end
         end

         // Destination root's rank and rows arrive; read source root
         JOIN_RD: begin
            rank_a_in = rk_rd;
            rows_a_in = rw_rd;
            tab_raddr = cur_ff;
            state_in  = JOIN_CMP;
         end

         // Link lower rank under higher; ties go under the source root
         JOIN_CMP: begin
            alu_op = ALU_ADD_SAT;
            alu_a  = rows_a_ff;
            alu_b  = rw_rd;
            sum_in = alu_res;
            par_we = 1'b1;
            if (rank_a_ff > rk_rd) begin
               top_in    = root_a_ff;
               par_waddr = cur_ff;
               par_wdata = root_a_ff;
            end else begin
               top_in    = cur_ff;
               par_waddr = root_a_ff;
               par_wdata = cur_ff;
               if (rank_a_ff == rk_rd && rk_rd != RANK_MAX) begin
                  rk_we    = 1'b1;
                  rk_waddr = cur_ff;
                  rk_wdata = rk_rd + RANK_W'(1);
               end
            end
            state_in = JOIN_WR;
         end

         // New root takes the summed rows
         JOIN_WR: begin
            rw_we        = 1'b1;
            rw_waddr     = top_ff;
            rw_wdata     = sum_ff;
            alu_b        = sum_ff;
            largest_in   = alu_res;
            state_in     = IDLE;
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end

         // Nothing to change, just answer
         DONE: begin
            state_in     = IDLE;
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         largest_ff   <= '0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         largest_ff   <= largest_in;
         clr_ff       <= clr_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      side_ff   <= side_in;
      node_ff   <= node_in;
      cur_ff    <= cur_in;
      walk_ff   <= walk_in;
      root_a_ff <= root_a_in;
      b_ff      <= b_in;
      top_ff    <= top_in;
      rows_ff   <= rows_in;
      rows_a_ff <= rows_a_in;
      sum_ff    <= sum_in;
      rank_a_ff <= rank_a_in;
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_largest_size = largest_ff;

`ifndef NO_ASSERTIONS
   // A response never overlaps work in progress
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // A taken request keeps the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but unit not busy");

   // A response only closes a request in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request");

   // The running maximum never falls
   a_largest_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> largest_ff >= $past(largest_ff))
      else $error("largest row count decreased");
`endif

endmodule

`default_nettype wire

>>> rtl/dsu_ram.sv
// ----------------------------------------------------------------------------
// dsu_ram
// Simple dual-port memory: one write port, one read port with registered
// read data. Read of an address written in the same cycle returns old data.
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/dsu_alu.sv
// ----------------------------------------------------------------------------
// dsu_alu
// Shared row-count unit: saturating add of two row counts, or the larger of
// two row counts.
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_alu (
   input  wire dsu_pkg::alu_op_type             op,
   input  wire logic [dsu_pkg::ROWS_W-1:0]      opnd_a,
   input  wire logic [dsu_pkg::ROWS_W-1:0]      opnd_b,
   output logic      [dsu_pkg::ROWS_W-1:0]      result
);

   import dsu_pkg::*;

   logic [ROWS_W:0] sum;

   // Full-width sum, carry out flags saturation
   assign sum = {1'b0, opnd_a} + {1'b0, opnd_b};

   always_comb begin
      unique case (op)
         ALU_ADD_SAT: result = sum[ROWS_W] ? '1 : sum[ROWS_W-1:0];
         ALU_MAX:     result = (opnd_a > opnd_b) ? opnd_a : opnd_b;
      endcase
   end

endmodule

`default_nettype wire
